// ----- src/pspd_pkg.sv -----
package pspd_pkg;

  // field widths
  localparam int SENDER_W  = 64;
  localparam int COMMAND_W = 8;
  localparam int PLAYER_W  = 12;
  localparam int CAP_W     = 12;
  localparam int SKIP_W    = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // counter store
  localparam int                 COUNTER_W   = 21;
  localparam logic [COUNTER_W-1:0] COUNTER_MAX = 21'h1F_FFFF;

  // limit = level * skip fits in 20 bits
  localparam int LIMIT_W = PLAYER_W + SKIP_W;

  // restoring divider, one quotient bit per step
  localparam int          DIV_STEPS  = PLAYER_W;
  localparam int          DIV_CNT_W  = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CROWD_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_PER_LEVEL = 1'd1;

  // register reset values
  localparam logic [CAP_W-1:0]  CROWD_CAPACITY_RST = 12'd50;
  localparam logic [SKIP_W-1:0] SKIP_PER_LEVEL_RST = 8'd1;

endpackage

// ----- src/per_sender_packet_decimator.sv -----
// per-sender packet decimator
//
// input channel: in_valid / in_stall carry one word per packet (sender_id,
// command_id, player_count). in_stall is high while a packet is in work, so
// one packet is processed at a time.
// output channel: out_valid / out_stall carry one word per packet (route,
// sender_was_new) from an output register; a new packet may be taken while a
// finished word still waits there.
// config port: cfg_write with cfg_index / cfg_data, written by the user only
// while idle; the block itself does not enforce it.
// a packet runs the player level on the divider, then the multiply, the slot
// scan up to the hit slot or over the valid slots, for a new sender the
// counter row clear, one entry per cycle, then counter read, update and
// output load; the next packet is taken the cycle after its word loads. the
// slot scan over the sender store (one read port) and the serial divider set
// the latency.
// reset empties the slot table; a slot's counter row is cleared whenever the
// slot is handed out, so no clearing pass runs after reset.
// a stalled output word holds; the last packet waits until the register frees.
module per_sender_packet_decimator #(
  parameter int SENDER_SLOTS = 64,
  parameter int COMMAND_IDS  = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pspd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pspd_pkg::SENDER_W-1:0]     sender_id,
  input  logic [pspd_pkg::COMMAND_W-1:0]    command_id,
  input  logic [pspd_pkg::PLAYER_W-1:0]     player_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              route,
  output logic                              sender_was_new
);

  import pspd_pkg::*;

  // slot index width, and a count width that can hold SENDER_SLOTS itself
  localparam int SLOT_W    = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam int FILL_W    = $clog2(SENDER_SLOTS + 1);
  localparam int CMDX_W    = $clog2(COMMAND_IDS);
  localparam int CNT_AW    = SLOT_W + CMDX_W;
  localparam int CNT_DEPTH = SENDER_SLOTS * (2 ** CMDX_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SEARCH,
    S_CLR,
    S_CNT_RD,
    S_UPD,
    S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [CAP_W-1:0]  crowd_capacity;
  logic [SKIP_W-1:0] skip_per_level;

  // packet in work
  logic [SENDER_W-1:0] sender_r;
  logic [CMDX_W-1:0]   cmd_idx;
  logic [LIMIT_W-1:0]  limit;
  logic [SLOT_W-1:0]   slot;
  logic                was_new_r;
  logic                route_r;
  logic                out_load;

  // slot table bookkeeping: slots fill in ring order, so valid = index below fill
  logic [SLOT_W-1:0] next_slot;
  logic [FILL_W-1:0] fill;

  // serial divider
  logic [PLAYER_W-1:0]  div_quo;
  logic [CAP_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CAP_W:0]       div_shift;
  logic [CAP_W:0]       div_diff;
  logic [CAP_W-1:0]     div_divisor;
  logic                 div_ge;
  logic                 div_last;
  logic [CAP_W-1:0]     div_rem_next;
  logic [PLAYER_W-1:0]  div_quo_next;

  // slot scan
  logic [FILL_W-1:0]   scan_idx;
  logic [SLOT_W-1:0]   cmp_idx;
  logic                cmp_live;
  logic [SLOT_W-1:0]   slot_raddr;
  logic [SENDER_W-1:0] slot_q;
  logic                slot_we;
  logic                hit;
  logic [SENDER_W-1:0] slot_mem [SENDER_SLOTS];

  // counter store
  logic [CMDX_W-1:0]    clr_idx;
  logic [COUNTER_W-1:0] cnt_mem [CNT_DEPTH];
  logic [COUNTER_W-1:0] cnt_q;
  logic [COUNTER_W-1:0] cnt_inc;
  logic [COUNTER_W-1:0] cnt_wdata;
  logic [CNT_AW-1:0]    cnt_raddr;
  logic [CNT_AW-1:0]    cnt_waddr;
  logic                 cnt_we;
  logic                 route_c;

  // command number to counter column, a constant table over every command value
  function automatic logic [CMDX_W-1:0] cmd_column(input logic [COMMAND_W-1:0] c);
    logic [CMDX_W-1:0] col;
    col = '0;
    for (int i = 0; i < (2 ** COMMAND_W); i++) begin
      if (c == COMMAND_W'(i)) begin
        col = CMDX_W'(i % COMMAND_IDS);
      end
    end
    return col;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // divider step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    div_divisor  = crowd_capacity;
    div_shift    = {div_rem, div_quo[PLAYER_W-1]};
    div_ge       = (div_shift >= {1'b0, div_divisor});
    div_diff     = div_shift - {1'b0, div_divisor};
    div_rem_next = div_ge ? div_diff[CAP_W-1:0] : div_shift[CAP_W-1:0];
    div_quo_next = {div_quo[PLAYER_W-2:0], div_ge};
    div_last     = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // scan compare sees the word read in the cycle before
  always_comb begin
    slot_raddr = (scan_idx < FILL_W'(SENDER_SLOTS)) ? scan_idx[SLOT_W-1:0] : '0;
    hit        = cmp_live && (slot_q == sender_r);
    slot_we    = (state == S_SEARCH) && !hit && !cmp_live;
  end

  // counter update with saturation, then compare against the limit
  always_comb begin
    cnt_inc   = (cnt_q < COUNTER_MAX) ? (cnt_q + COUNTER_W'(1)) : cnt_q;
    route_c   = (cnt_inc > COUNTER_W'(limit));
    cnt_raddr = {slot, cmd_idx};
    cnt_we    = (state == S_CLR) || (state == S_UPD);
    cnt_waddr = (state == S_CLR) ? {slot, clr_idx} : {slot, cmd_idx};
    cnt_wdata = ((state == S_CLR) || route_c) ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[next_slot] <= sender_r;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      fill           <= '0;
      next_slot      <= '0;
      scan_idx       <= '0;
      cmp_live       <= 1'b0;
      crowd_capacity <= CROWD_CAPACITY_RST;
      skip_per_level <= SKIP_PER_LEVEL_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CROWD_CAPACITY: crowd_capacity <= cfg_data[CAP_W-1:0];
          REG_SKIP_PER_LEVEL: skip_per_level <= cfg_data[SKIP_W-1:0];
          default: ;
        endcase
      end

      // output register: load a finished word, or empty once it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sender_r <= sender_id;
            cmd_idx  <= cmd_column(command_id);
            div_quo  <= player_count;
            div_rem  <= '0;
            div_cnt  <= '0;
            scan_idx <= '0;
            state    <= S_DIV;
          end
        end

        // player_count / crowd_capacity
        S_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_last) begin
            state <= S_MUL;
          end
        end

        // zero capacity means level zero; slot 0 is being read meanwhile
        S_MUL: begin
          limit    <= (crowd_capacity == '0) ? '0
                      : LIMIT_W'(div_quo) * LIMIT_W'(skip_per_level);
          cmp_idx  <= '0;
          cmp_live <= (fill != '0);
          scan_idx <= FILL_W'(1);
          state    <= S_SEARCH;
        end

        S_SEARCH: begin
          if (hit) begin
            slot      <= cmp_idx;
            was_new_r <= 1'b0;
            state     <= S_CNT_RD;
          end else if (!cmp_live) begin
            // miss: take the ring slot, evicting its sender when full
            slot      <= next_slot;
            was_new_r <= 1'b1;
            next_slot <= (next_slot == SLOT_W'(SENDER_SLOTS - 1)) ? '0
                         : next_slot + SLOT_W'(1);
            if (fill != FILL_W'(SENDER_SLOTS)) begin
              fill <= fill + FILL_W'(1);
            end
            clr_idx   <= '0;
            state     <= S_CLR;
          end else begin
            cmp_idx  <= scan_idx[SLOT_W-1:0];
            cmp_live <= (scan_idx < fill);
            scan_idx <= scan_idx + FILL_W'(1);
          end
        end

        // clear the new slot's counter row
        S_CLR: begin
          clr_idx <= clr_idx + CMDX_W'(1);
          if (clr_idx == CMDX_W'(COMMAND_IDS - 1)) begin
            state <= S_CNT_RD;
          end
        end

        S_CNT_RD: begin
          state <= S_UPD;
        end

        S_UPD: begin
          route_r <= route_c;
          state   <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            route          <= route_r;
            sender_was_new <= was_new_r;
            scan_idx       <= '0;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ring pointer tracks the fill count until the table is full
  assert property (@(posedge clk) disable iff (rst)
    (fill != FILL_W'(SENDER_SLOTS)) |-> (next_slot == SLOT_W'(fill)))
    else $error("next_slot out of step with fill count");

  assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(SENDER_SLOTS))
    else $error("fill count beyond slot count");

  // a hit can only come from a valid slot
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && hit) |-> (FILL_W'(cmp_idx) < fill))
    else $error("slot hit beyond valid slots");

  // divider remainder settles below the capacity
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (crowd_capacity == '0 || div_rem < crowd_capacity))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output word loaded outside final state");

endmodule
